FILE: rtl/core/amcd_pkg.sv
package amcd_pkg;

	localparam int unsigned LenWidth = 32;

	localparam logic [7:0] CHAR_0 = 8'h30;
	localparam logic [7:0] CHAR_1 = 8'h31;
	localparam logic [7:0] CHAR_W = 8'h77;
	localparam logic [7:0] CHAR_D = 8'h64;
	localparam logic [7:0] CHAR_B = 8'h62;
	localparam logic [7:0] CHAR_C = 8'h63;

	localparam logic [3:0] POS_ID0  = 4'd0;
	localparam logic [3:0] POS_ID1  = 4'd1;
	localparam logic [3:0] POS_ID2  = 4'd2;
	localparam logic [3:0] POS_ID3  = 4'd3;
	localparam logic [3:0] POS_LEN0 = 4'd4;
	localparam logic [3:0] POS_LEN1 = 4'd5;
	localparam logic [3:0] POS_LEN2 = 4'd6;
	localparam logic [3:0] POS_LEN3 = 4'd7;
	localparam logic [3:0] POS_BODY = 4'd8;

	typedef enum logic [1:0] {
		KIND_NONE  = 2'd0,
		KIND_AUDIO = 2'd1,
		KIND_VIDEO = 2'd2
	} kind_t;

endpackage

FILE: rtl/core/avi_movi_chunk_deframer_core.sv
// Chunk deframer for the byte stream inside an AVI movi list.
// Raw stream bytes arrive one per request on the s_ channel. The block hunts
// for a chunk id of '0', a stream digit '0' or '1', then "wb" for audio or
// "dc" for video, reads the following 32-bit little-endian length and passes
// that many payload bytes out on the m_ channel. Each output request carries
// the byte in m_tdata, the end-of-chunk mark in m_tlast and the chunk kind,
// stream digit and empty-chunk flag in m_tuser. A chunk of length zero gives
// one request with empty_chunk and tlast set and a zero data byte. Header
// bytes and bytes that break the id match produce no output.
// An accepted input byte passes through one input register and one result
// register on its way to its output request. The block accepts one byte in
// every cycle as long as the result register is free or is being emptied in
// the same cycle, so the sustained rate is one byte per cycle.
// When the receiver stalls, the result register holds its request and the
// input register fills; after that s_tready drops until m_tready returns.
// Reset returns the parser to the id hunt and empties both registers.
module avi_movi_chunk_deframer_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] in_byte
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] out_byte
	output logic       m_tlast,   // last_of_chunk
	output logic [2:0] m_tuser    // [0] is_video, [1] stream_digit, [2] empty_chunk
);
	import amcd_pkg::*;

	logic                valid_s1;
	logic [7:0]          byte_s1;
	logic                advance;

	logic [3:0]          pos_q, pos_d;
	kind_t               kind_q, kind_d;
	logic                digit_q, digit_d;
	logic [23:0]         len_q, len_d;
	logic [LenWidth-1:0] rem_q, rem_d;
	logic                body_q, body_d;

	logic [31:0]         len_full;
	logic [LenWidth-1:0] len_trunc;
	logic                res_valid, res_last, res_empty;
	logic [7:0]          res_byte;
	logic                last_byte;

	logic                out_valid_q;
	logic [7:0]          out_byte_q;
	logic                out_video_q, out_digit_q, out_last_q, out_empty_q;

	assign advance  = !out_valid_q || m_tready;
	assign s_tready = !valid_s1 || advance;

	assign len_full  = {byte_s1, len_q};
	assign len_trunc = len_full[LenWidth-1:0];
	assign last_byte = (rem_q <= LenWidth'(1));

	always_comb begin
		pos_d     = pos_q;
		kind_d    = kind_q;
		digit_d   = digit_q;
		len_d     = len_q;
		rem_d     = rem_q;
		body_d    = body_q;
		res_valid = 1'b0;
		res_last  = 1'b0;
		res_empty = 1'b0;
		res_byte  = byte_s1;
		if (body_q) begin
			res_valid = 1'b1;
			res_last  = last_byte;
			if (last_byte) begin
				rem_d  = '0;
				body_d = 1'b0;
				pos_d  = POS_ID0;
			end else begin
				rem_d = rem_q - LenWidth'(1);
			end
		end else begin
			case (pos_q)
				POS_ID0: begin
					pos_d = (byte_s1 == CHAR_0) ? POS_ID1 : POS_ID0;
				end
				POS_ID1: begin
					if (byte_s1 == CHAR_0 || byte_s1 == CHAR_1) begin
						digit_d = (byte_s1 == CHAR_1);
						pos_d   = POS_ID2;
					end else begin
						pos_d = POS_ID0;
					end
				end
				POS_ID2: begin
					if (byte_s1 == CHAR_W) begin
						kind_d = KIND_AUDIO;
						pos_d  = POS_ID3;
					end else if (byte_s1 == CHAR_D) begin
						kind_d = KIND_VIDEO;
						pos_d  = POS_ID3;
					end else begin
						pos_d = POS_ID0;
					end
				end
				POS_ID3: begin
					if ((byte_s1 == CHAR_B && kind_q == KIND_AUDIO) ||
					    (byte_s1 == CHAR_C && kind_q == KIND_VIDEO)) begin
						pos_d = POS_LEN0;
					end else begin
						pos_d = POS_ID0;
					end
				end
				POS_LEN0: begin
					len_d = {16'd0, byte_s1};
					pos_d = POS_LEN1;
				end
				POS_LEN1: begin
					len_d[15:8] = byte_s1;
					pos_d       = POS_LEN2;
				end
				POS_LEN2: begin
					len_d[23:16] = byte_s1;
					pos_d        = POS_LEN3;
				end
				POS_LEN3: begin
					if (len_trunc == '0) begin
						pos_d     = POS_ID0;
						res_valid = 1'b1;
						res_last  = 1'b1;
						res_empty = 1'b1;
						res_byte  = 8'd0;
					end else begin
						rem_d  = len_trunc;
						body_d = 1'b1;
						pos_d  = POS_BODY;
					end
				end
				default: begin
					pos_d = POS_ID0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= POS_ID0;
			kind_q  <= KIND_NONE;
			digit_q <= 1'b0;
			len_q   <= '0;
			rem_q   <= '0;
			body_q  <= 1'b0;
		end else if (valid_s1 && advance) begin
			pos_q   <= pos_d;
			kind_q  <= kind_d;
			digit_q <= digit_d;
			len_q   <= len_d;
			rem_q   <= rem_d;
			body_q  <= body_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1 && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1 && res_valid) begin
			out_byte_q  <= res_byte;
			out_video_q <= (kind_q == KIND_VIDEO);
			out_digit_q <= digit_q;
			out_last_q  <= res_last;
			out_empty_q <= res_empty;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_byte_q;
	assign m_tlast  = out_last_q;
	assign m_tuser  = {out_empty_q, out_digit_q, out_video_q};

endmodule

FILE: verif/chunk_stream_checker.sv
module chunk_stream_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	input  logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] in_byte
	input  logic       m_tvalid,
	input  logic       m_tready,
	input  logic [7:0] m_tdata,   // [7:0] out_byte
	input  logic       m_tlast,   // last_of_chunk
	input  logic [2:0] m_tuser,   // [0] is_video, [1] stream_digit, [2] empty_chunk
	output int         fail_count,
	output int         bytes_due,
	output int         requests_checked
);
	import amcd_pkg::*;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       is_video;
		logic       stream_digit;
		logic       last_of_chunk;
		logic       empty_chunk;
	} chunk_byte_t;

	chunk_byte_t                due_q[$];
	chunk_byte_t                due;
	logic        [3:0]          hdr_pos;
	kind_t                      kind;
	logic                       digit;
	logic        [LenWidth-1:0] chunk_len;
	logic        [LenWidth-1:0] left;
	logic                       in_body;
	int                         mismatches;
	int                         checked;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_pos = POS_ID0;
			kind = KIND_NONE;
			digit = 1'b0;
			chunk_len = '0;
			left = '0;
			in_body = 1'b0;
			due_q.delete();
			mismatches = 0;
			checked = 0;
			fail_count <= 0;
			bytes_due <= 0;
			requests_checked <= 0;
		end else begin
			if (s_tvalid && s_tready) begin
				if (in_body) begin
					due.out_byte = s_tdata;
					due.is_video = (kind == KIND_VIDEO);
					due.stream_digit = digit;
					due.last_of_chunk = (left <= 1);
					due.empty_chunk = 1'b0;
					due_q.push_back(due);
					left = left - 1'b1;
					if (due.last_of_chunk) begin
						left = '0;
						in_body = 1'b0;
						hdr_pos = POS_ID0;
					end
				end else begin
					case (hdr_pos)
						POS_ID0: begin
							hdr_pos = (s_tdata == CHAR_0) ? POS_ID1 : POS_ID0;
						end
						POS_ID1: begin
							if (s_tdata == CHAR_0 || s_tdata == CHAR_1) begin
								digit = (s_tdata == CHAR_1);
								hdr_pos = POS_ID2;
							end else begin
								hdr_pos = POS_ID0;
							end
						end
						POS_ID2: begin
							if (s_tdata == CHAR_W) begin
								kind = KIND_AUDIO;
								hdr_pos = POS_ID3;
							end else if (s_tdata == CHAR_D) begin
								kind = KIND_VIDEO;
								hdr_pos = POS_ID3;
							end else begin
								hdr_pos = POS_ID0;
							end
						end
						POS_ID3: begin
							if ((s_tdata == CHAR_B && kind == KIND_AUDIO) ||
							    (s_tdata == CHAR_C && kind == KIND_VIDEO))
								hdr_pos = POS_LEN0;
							else
								hdr_pos = POS_ID0;
						end
						POS_LEN0: begin
							chunk_len = LenWidth'(s_tdata);
							hdr_pos = POS_LEN1;
						end
						POS_LEN1, POS_LEN2: begin
							chunk_len = chunk_len |
								(LenWidth'(s_tdata) << (8 * (hdr_pos - POS_LEN0)));
							hdr_pos = hdr_pos + 1'b1;
						end
						POS_LEN3: begin
							chunk_len = chunk_len | (LenWidth'(s_tdata) << 24);
							if (chunk_len == 0) begin
								due.out_byte = 8'h00;
								due.is_video = (kind == KIND_VIDEO);
								due.stream_digit = digit;
								due.last_of_chunk = 1'b1;
								due.empty_chunk = 1'b1;
								due_q.push_back(due);
								hdr_pos = POS_ID0;
							end else begin
								left = chunk_len;
								in_body = 1'b1;
								hdr_pos = POS_BODY;
							end
						end
						default: begin
							hdr_pos = POS_ID0;
						end
					endcase
				end
			end
			if (m_tvalid && m_tready) begin
				checked++;
				if (due_q.size() == 0) begin
					$error("output request with none due: out_byte %02h", m_tdata);
					mismatches++;
				end else begin
					due = due_q.pop_front();
					if (m_tdata !== due.out_byte) begin
						$error("out_byte: expected %02h, got %02h", due.out_byte, m_tdata);
						mismatches++;
					end
					if (m_tuser[0] !== due.is_video) begin
						$error("is_video: expected %0b, got %0b", due.is_video, m_tuser[0]);
						mismatches++;
					end
					if (m_tuser[1] !== due.stream_digit) begin
						$error("stream_digit: expected %0b, got %0b", due.stream_digit,
							m_tuser[1]);
						mismatches++;
					end
					if (m_tlast !== due.last_of_chunk) begin
						$error("last_of_chunk: expected %0b, got %0b", due.last_of_chunk,
							m_tlast);
						mismatches++;
					end
					if (m_tuser[2] !== due.empty_chunk) begin
						$error("empty_chunk: expected %0b, got %0b", due.empty_chunk,
							m_tuser[2]);
						mismatches++;
					end
				end
			end
			fail_count <= mismatches;
			bytes_due <= due_q.size();
			requests_checked <= checked;
		end
	end

endmodule

FILE: verif/tb_avi_movi_chunk_deframer_core.sv
module tb_avi_movi_chunk_deframer_core;
	import amcd_pkg::*;

	localparam int         CycleLimit = 200000;
	localparam int         SettleCycles = 8;
	localparam int         PhaseItems = 300;
	localparam logic [7:0] HuntBreak = 8'hE0;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       s_tvalid;
	logic       s_tready;
	logic [7:0] s_tdata;
	logic       m_tvalid;
	logic       m_tready = 1'b0;
	logic [7:0] m_tdata;
	logic       m_tlast;
	logic [2:0] m_tuser;

	int fail_count;
	int bytes_due;
	int requests_checked;
	int tx_idle_pct;
	int rx_idle_pct;
	int cycles = 0;
	int items_sent;
	int ignored_sent;
	int chunks_sent;
	int empty_sent;
	int broken_sent;

	avi_movi_chunk_deframer_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast),
		.m_tuser(m_tuser)
	);

	chunk_stream_checker chunk_check (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast),
		.m_tuser(m_tuser),
		.fail_count(fail_count),
		.bytes_due(bytes_due),
		.requests_checked(requests_checked)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= rx_idle_pct);
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CycleLimit) begin
			$display("tb: failure");
			$finish;
		end
	end

	task automatic send_byte(input logic [7:0] value);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= value;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		items_sent++;
	endtask

	task automatic send_chunk(input logic digit, input logic video, input int len);
		logic [31:0] len_bits;
		len_bits = len;
		send_byte(CHAR_0);
		send_byte(digit ? CHAR_1 : CHAR_0);
		send_byte(video ? CHAR_D : CHAR_W);
		send_byte(video ? CHAR_C : CHAR_B);
		for (int i = 0; i < 4; i++)
			send_byte(len_bits[8*i +: 8]);
		for (int i = 0; i < len; i++)
			send_byte(8'($urandom_range(255)));
		chunks_sent++;
		if (len == 0)
			empty_sent++;
	endtask

	// Stops sending until every due output request has been seen.
	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (bytes_due != 0)
			@(posedge clk);
		repeat (SettleCycles) @(posedge clk);
	endtask

	// Mostly well-formed chunks; the rest are ids cut short by a wrong byte and
	// short runs of noise. Both leave the hunt at its start so that the next
	// chunk is framed.
	task automatic run_random(input int count);
		int         stop;
		int         pick;
		int         len;
		int         k;
		int         n;
		logic       digit;
		logic       video;
		logic [7:0] id[4];
		logic [7:0] near_miss[6];
		logic [7:0] b;
		near_miss = '{CHAR_0, CHAR_1, CHAR_W, CHAR_D, CHAR_B, CHAR_C};
		stop = items_sent - ignored_sent + count;
		while (items_sent - ignored_sent < stop) begin
			pick = $urandom_range(99);
			digit = 1'($urandom_range(1));
			video = 1'($urandom_range(1));
			if (pick < 70) begin
				len = $urandom_range(99);
				if (len < 10)
					len = 0;
				else if (len < 97)
					len = $urandom_range(12, 1);
				else
					len = $urandom_range(264, 256);
				send_chunk(digit, video, len);
			end else if (pick < 88) begin
				id[0] = CHAR_0;
				id[1] = digit ? CHAR_1 : CHAR_0;
				id[2] = video ? CHAR_D : CHAR_W;
				id[3] = video ? CHAR_C : CHAR_B;
				k = $urandom_range(3, 1);
				for (int i = 0; i < k; i++)
					send_byte(id[i]);
				b = $urandom_range(1) ? near_miss[3'($urandom_range(5))] :
					8'($urandom_range(255));
				if ((k == 1 && (b == CHAR_0 || b == CHAR_1)) ||
				    (k == 2 && (b == CHAR_W || b == CHAR_D)) ||
				    (k == 3 && b == id[3]))
					b = HuntBreak;
				send_byte(b);
				broken_sent++;
			end else begin
				n = $urandom_range(3, 1);
				repeat (n) send_byte(8'($urandom_range(255)));
				send_byte(HuntBreak);
				ignored_sent += n + 1;
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = 8'h00;
		tx_idle_pct = 26;
		rx_idle_pct = 82;
		items_sent = 0;
		ignored_sent = 0;
		chunks_sent = 0;
		empty_sent = 0;
		broken_sent = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_chunk(1'b0, 1'b0, 0);
		send_byte(CHAR_0);
		send_byte(CHAR_1);
		send_byte(CHAR_D);
		send_byte(CHAR_C);
		send_byte(8'h02);
		send_byte(8'h00);
		send_byte(8'h00);
		send_byte(8'h00);
		send_byte(8'h00);
		send_byte(8'hFF);
		chunks_sent++;
		send_byte(CHAR_0);
		send_byte(HuntBreak);
		send_byte(CHAR_0);
		send_byte(CHAR_0);
		send_byte(CHAR_W);
		send_byte(CHAR_C);
		broken_sent += 2;

		run_random(PhaseItems);
		settle();
		tx_idle_pct <= 82;
		rx_idle_pct <= 26;
		run_random(PhaseItems);
		settle();
		tx_idle_pct <= 0;
		rx_idle_pct <= 0;
		run_random(PhaseItems);
		settle();

		$display("Sent %0d stream bytes (%0d noise): %0d chunks, %0d empty, %0d broken ids.",
			items_sent, ignored_sent, chunks_sent, empty_sent, broken_sent);
		$display("Checked %0d output requests under three stall patterns.", requests_checked);
		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
